FILE: rtl/core/three_plane_intersection_assert.svh
// ----------------------------------------------------------------------------
// Three-plane intersection assertion macros
// Shared property forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef THREE_PLANE_INTERSECTION_ASSERT_SVH
`define THREE_PLANE_INTERSECTION_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TPI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpi check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpi check failed");

`endif

FILE: rtl/core/tpi_pkg.sv
// ----------------------------------------------------------------------------
// Three-plane intersection package
// Fixed result widths, queue depth, flag struct and index helpers.
// ----------------------------------------------------------------------------
package tpi_pkg;

	localparam int PT_W   = 32;  // width of a result coordinate
	localparam int QDEPTH = 8;   // determinant queue between front and back

	typedef struct packed {
		logic singular;
		logic overflow;
	} tpi_flags_t;

	// first and second member of pair p: 0 -> (1,2), 1 -> (0,2), 2 -> (0,1)
	function automatic logic [1:0] pair_lo(input logic [1:0] p);
		return (p == 2'd0) ? 2'd1 : 2'd0;
	endfunction

	function automatic logic [1:0] pair_hi(input logic [1:0] p);
		return (p == 2'd2) ? 2'd1 : 2'd2;
	endfunction

endpackage

FILE: rtl/core/tpi_fifo.sv
// ----------------------------------------------------------------------------
// Determinant queue
// Small register queue, first word visible at the head, count for credits.
// ----------------------------------------------------------------------------
module tpi_fifo import tpi_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr,
	input  logic [WIDTH-1:0]             din,
	input  logic                         rd,
	output logic [WIDTH-1:0]             dout,
	output logic                         empty,
	output logic [$clog2(DEPTH):0]       count
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign dout  = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + AW'(1);
			end
			if (rd) begin
				rp_q <= rp_q + AW'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: rtl/core/tpi_front.sv
// ----------------------------------------------------------------------------
// Determinant front end
// Five-stage pipeline: 2x2 minors, split minor-by-coefficient products,
// cofactor sums for Dm, Dx, Dy, Dz and the singular classification.
// ----------------------------------------------------------------------------
module tpi_front import tpi_pkg::*; #(
	parameter int CW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  logic signed [CW-1:0]  col_a [3],
	input  logic signed [CW-1:0]  col_b [3],
	input  logic signed [CW-1:0]  col_c [3],
	input  logic signed [CW-1:0]  col_d [3],
	output logic                  out_vld,
	output logic                  out_sing,
	output logic signed [3*CW+1:0] det [4]
);
	localparam int PW = 2*CW;      // 2x2 product
	localparam int MW = 2*CW + 1;  // minor, also split product
	localparam int TW = 3*CW + 1;  // cofactor term
	localparam int DW = 3*CW + 2;  // determinant

	logic signed [CW-1:0] col [3][3];
	logic signed [PW-1:0] pp_c [3][3][2];

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [PW-1:0] pp_s1 [3][3][2];
	logic signed [CW-1:0] a_s1 [3], d_s1 [3], a_s2 [3], d_s2 [3];
	logic signed [MW-1:0] mn_s2 [3][3];
	logic signed [MW-1:0] ph_s3 [4][3], pl_s3 [4][3];
	logic signed [TW-1:0] tm_s4 [4][3];
	logic signed [DW-1:0] det_s5 [4];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			col[0][r] = col_a[r];
			col[1][r] = col_b[r];
			col[2][r] = col_c[r];
		end
		// minor(cp, rows m) = x_i*y_j - x_j*y_i
		for (int cp = 0; cp < 3; cp++) begin
			for (int m = 0; m < 3; m++) begin
				pp_c[cp][m][0] = PW'(col[pair_lo(2'(cp))][pair_lo(2'(m))])
					* PW'(col[pair_hi(2'(cp))][pair_hi(2'(m))]);
				pp_c[cp][m][1] = PW'(col[pair_lo(2'(cp))][pair_hi(2'(m))])
					* PW'(col[pair_hi(2'(cp))][pair_lo(2'(m))]);
			end
		end
	end

	// t0: a with (b,c) -> Dm; t1: d with (b,c); t2: d with (a,c); t3: d with (a,b)
	function automatic logic [1:0] term_cp(input logic [1:0] t);
		return (t == 2'd0) ? 2'd0 : t - 2'd1;
	endfunction

	always_ff @(posedge clk) begin
		pp_s1 <= pp_c;
		a_s1  <= col_a;
		d_s1  <= col_d;

		for (int cp = 0; cp < 3; cp++) begin
			for (int m = 0; m < 3; m++) begin
				mn_s2[cp][m] <= MW'(pp_s1[cp][m][0]) - MW'(pp_s1[cp][m][1]);
			end
		end
		a_s2 <= a_s1;
		d_s2 <= d_s1;

		for (int t = 0; t < 4; t++) begin
			for (int m = 0; m < 3; m++) begin
				ph_s3[t][m] <= MW'($signed(mn_s2[term_cp(2'(t))][m][MW-1:CW]))
					* MW'((t == 0) ? a_s2[m] : d_s2[m]);
				pl_s3[t][m] <= MW'($signed({1'b0, mn_s2[term_cp(2'(t))][m][CW-1:0]}))
					* MW'((t == 0) ? a_s2[m] : d_s2[m]);
			end
		end

		for (int t = 0; t < 4; t++) begin
			for (int m = 0; m < 3; m++) begin
				tm_s4[t][m] <= (TW'(ph_s3[t][m]) <<< CW) + TW'(pl_s3[t][m]);
			end
		end

		// Dx and Dz come out negated since the column holds d, not -d
		for (int t = 0; t < 4; t++) begin
			if (t == 1 || t == 3) begin
				det_s5[t] <= DW'(tm_s4[t][1]) - DW'(tm_s4[t][0]) - DW'(tm_s4[t][2]);
			end else begin
				det_s5[t] <= DW'(tm_s4[t][0]) - DW'(tm_s4[t][1]) + DW'(tm_s4[t][2]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign out_vld  = vld_s5;
	assign out_sing = (det_s5[0] == '0);
	assign det      = det_s5;
endmodule

FILE: rtl/core/tpi_back.sv
// ----------------------------------------------------------------------------
// Division back end
// Stallable pipeline: sign strip, range precheck, one quotient bit per stage
// for three lanes sharing the denominator, then saturation into the output
// register.
// ----------------------------------------------------------------------------
module tpi_back import tpi_pkg::*; #(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_empty,
	output logic                   in_rd,
	input  logic                   in_sing,
	input  logic signed [3*CW+1:0] in_det [4],
	output logic                   out_empty,
	input  logic                   out_pop,
	output logic [PT_W-1:0]        out_pt [3],
	output tpi_flags_t             out_flags
);
	localparam int DW = 3*CW + 2;
	localparam int RW = DW + FB + PT_W + 1;
	localparam int QW = PT_W;

	logic en, take;

	logic            vld_s1, sing_s1;
	logic [DW-1:0]   dabs_s1;
	logic [DW-1:0]   nabs_s1 [3];
	logic            neg_s1 [3];

	logic            vld_s [0:QW];
	logic            sing_s [0:QW];
	logic [RW-1:0]   den_s [0:QW];
	logic [RW-1:0]   rem_s [0:QW][3];
	logic [QW-1:0]   quo_s [0:QW][3];
	logic            neg_s [0:QW][3];
	logic            big_s [0:QW][3];

	logic            vld_out_q;
	logic [QW-1:0]   pt_q [3];
	tpi_flags_t      flags_q;
	logic [QW-1:0]   pt_c [3];
	logic            sat_c [3];

	assign en    = !vld_out_q || out_pop;
	assign take  = en && !in_empty;
	assign in_rd = take;

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s1 <= in_sing;
			dabs_s1 <= in_det[0][DW-1] ? DW'(-in_det[0]) : DW'(in_det[0]);
			for (int i = 0; i < 3; i++) begin
				nabs_s1[i] <= in_det[i+1][DW-1] ? DW'(-in_det[i+1]) : DW'(in_det[i+1]);
				neg_s1[i]  <= in_det[i+1][DW-1] ^ in_det[0][DW-1];
			end

			// quotient of 2^32 or more cannot fit any result
			sing_s[0] <= sing_s1;
			den_s[0]  <= RW'(dabs_s1);
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= RW'(nabs_s1[i]) << FB;
				quo_s[0][i] <= '0;
				neg_s[0][i] <= neg_s1[i];
				big_s[0][i] <= (RW'(nabs_s1[i]) << FB) >= (RW'(dabs_s1) << QW);
			end
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_div
		localparam int K = QW - j;
		logic [RW-1:0] dsh;
		logic          ge [3];

		always_comb begin
			dsh = den_s[j-1] << K;
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[j-1][i] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= den_s[j-1];
				sing_s[j] <= sing_s[j-1];
				for (int i = 0; i < 3; i++) begin
					rem_s[j][i] <= ge[i] ? rem_s[j-1][i] - dsh : rem_s[j-1][i];
					quo_s[j][i] <= {quo_s[j-1][i][QW-2:0], ge[i]};
					neg_s[j][i] <= neg_s[j-1][i];
					big_s[j][i] <= big_s[j-1][i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat_c[i] = big_s[QW][i]
				|| (!neg_s[QW][i] && quo_s[QW][i][QW-1])
				|| (neg_s[QW][i] && (quo_s[QW][i] > {1'b1, {(QW-1){1'b0}}}));
			if (sing_s[QW]) begin
				pt_c[i] = '0;
			end else if (sat_c[i]) begin
				pt_c[i] = neg_s[QW][i] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
			end else begin
				pt_c[i] = neg_s[QW][i] ? -quo_s[QW][i] : quo_s[QW][i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_q             <= pt_c;
			flags_q.singular <= sing_s[QW];
			flags_q.overflow <= !sing_s[QW] && (sat_c[0] || sat_c[1] || sat_c[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s[0]  <= 1'b0;
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= take;
			vld_s[0]  <= vld_s1;
			vld_out_q <= vld_s[QW];
		end
	end

	assign out_empty = !vld_out_q;
	assign out_pt    = pt_q;
	assign out_flags = flags_q;
endmodule

FILE: rtl/core/three_plane_intersection.sv
// Path: from the accepting edge through 5 determinant stages, the queue and
//   35 back-end stages to the result in the output register.
// Throughput: one item per cycle; the divider pipeline advances whenever the
//   output register is empty or being popped, one quotient bit per stage.
// Reset: arst_n clears all valid bits, queue pointers and the credit count;
//   datapath registers are not reset.
// ----------------------------------------------------------------------------
// Three-plane intersection by Cramer's rule
// Front end forms Dm, Dx, Dy, Dz exactly and flags singular systems; a short
// queue decouples it from the stallable back end that divides and saturates.
// ----------------------------------------------------------------------------
`include "three_plane_intersection_assert.svh"

module three_plane_intersection import tpi_pkg::*; #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COEF_WIDTH-1:0] plane1_a,
	input  logic signed [COEF_WIDTH-1:0] plane1_b,
	input  logic signed [COEF_WIDTH-1:0] plane1_c,
	input  logic signed [COEF_WIDTH-1:0] plane1_d,
	input  logic signed [COEF_WIDTH-1:0] plane2_a,
	input  logic signed [COEF_WIDTH-1:0] plane2_b,
	input  logic signed [COEF_WIDTH-1:0] plane2_c,
	input  logic signed [COEF_WIDTH-1:0] plane2_d,
	input  logic signed [COEF_WIDTH-1:0] plane3_a,
	input  logic signed [COEF_WIDTH-1:0] plane3_b,
	input  logic signed [COEF_WIDTH-1:0] plane3_c,
	input  logic signed [COEF_WIDTH-1:0] plane3_d,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [PT_W-1:0]       point_x,
	output logic signed [PT_W-1:0]       point_y,
	output logic signed [PT_W-1:0]       point_z,
	output logic                         singular,
	output logic                         overflow
);
	localparam int DW   = 3*COEF_WIDTH + 2;     // exact determinant width
	localparam int QDW  = 4*DW + 1;             // queue entry: 4 dets + singular
	localparam int CNTW = $clog2(QDEPTH) + 1;

	logic signed [COEF_WIDTH-1:0] col_a [3], col_b [3], col_c [3], col_d [3];

	logic                 acc;
	logic                 f_vld, f_sing;
	logic signed [DW-1:0] f_det [4];

	logic [QDW-1:0]       q_din, q_dout;
	logic                 q_empty, q_rd;
	logic [CNTW-1:0]      q_cnt;

	logic                 b_sing;
	logic signed [DW-1:0] b_det [4];
	logic [PT_W-1:0]      b_pt [3];
	tpi_flags_t           b_flags;

	// items inside the front pipeline; together with the queue fill this is
	// the credit that keeps the queue from ever overflowing
	logic [CNTW-1:0]      infl_q;
	logic [CNTW:0]        used;

	assign col_a = '{plane1_a, plane2_a, plane3_a};
	assign col_b = '{plane1_b, plane2_b, plane3_b};
	assign col_c = '{plane1_c, plane2_c, plane3_c};
	assign col_d = '{plane1_d, plane2_d, plane3_d};

	assign used = (CNTW+1)'(infl_q) + (CNTW+1)'(q_cnt);
	assign full = (used >= (CNTW+1)'(QDEPTH));
	assign acc  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else begin
			case ({acc, f_vld})
				2'b10:   infl_q <= infl_q + CNTW'(1);
				2'b01:   infl_q <= infl_q - CNTW'(1);
				default: infl_q <= infl_q;
			endcase
		end
	end

	tpi_front #(
		.CW(COEF_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (acc),
		.col_a    (col_a),
		.col_b    (col_b),
		.col_c    (col_c),
		.col_d    (col_d),
		.out_vld  (f_vld),
		.out_sing (f_sing),
		.det      (f_det)
	);

	assign q_din = {f_sing, f_det[0], f_det[1], f_det[2], f_det[3]};

	tpi_fifo #(
		.WIDTH(QDW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_vld),
		.din    (q_din),
		.rd     (q_rd),
		.dout   (q_dout),
		.empty  (q_empty),
		.count  (q_cnt)
	);

	assign b_sing = q_dout[QDW-1];
	always_comb begin
		for (int t = 0; t < 4; t++) begin
			b_det[t] = q_dout[(3-t)*DW +: DW];
		end
	end

	tpi_back #(
		.CW(COEF_WIDTH),
		.FB(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_empty  (q_empty),
		.in_rd     (q_rd),
		.in_sing   (b_sing),
		.in_det    (b_det),
		.out_empty (empty),
		.out_pop   (pop),
		.out_pt    (b_pt),
		.out_flags (b_flags)
	);

	assign point_x  = b_pt[0];
	assign point_y  = b_pt[1];
	assign point_z  = b_pt[2];
	assign singular = b_flags.singular;
	assign overflow = b_flags.overflow;

	// credit never exceeds the queue depth
	`TPI_ASSERT_NOW(a_credit_bound, 1'b1, used <= (CNTW+1)'(QDEPTH))
	// a front transfer always finds room in the queue
	`TPI_ASSERT_NOW(a_queue_room, f_vld, q_cnt < CNTW'(QDEPTH))
	// a singular result carries a zero point and no overflow
	`TPI_ASSERT_NOW(a_sing_zero, !empty && singular,
		point_x == '0 && point_y == '0 && point_z == '0 && !overflow)
	// the back end only drains the queue when it holds data
	`TPI_ASSERT_NOW(a_no_underrun, q_rd, !q_empty)
endmodule

FILE: sim/tb_three_plane_intersection.sv
// ----------------------------------------------------------------------------
// Three-plane intersection testbench
// Drives plane triples through the push/full queue port, predicts each point
// with exact wide Cramer arithmetic and checks every popped result in order.
// ----------------------------------------------------------------------------
module tb_three_plane_intersection;
	import tpi_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LATENCY = 41;

	typedef logic signed [CW-1:0] coef_t;
	// exact products of three coefficients fit well inside 128 bits
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic signed [PT_W-1:0] z;
		logic                   sing;
		logic                   ovf;
	} point_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic empty;
	logic pop;
	coef_t pl [12];
	logic signed [PT_W-1:0] point_x, point_y, point_z;
	logic singular, overflow;

	point_t expected_points[$];
	int     errors;
	int     n_sent;
	int     n_checked;
	int     n_singular;
	int     n_overflow;
	bit     idle_enable;
	bit     hold_pop;

	three_plane_intersection u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.plane1_a (pl[0]),
		.plane1_b (pl[1]),
		.plane1_c (pl[2]),
		.plane1_d (pl[3]),
		.plane2_a (pl[4]),
		.plane2_b (pl[5]),
		.plane2_c (pl[6]),
		.plane2_d (pl[7]),
		.plane3_a (pl[8]),
		.plane3_b (pl[9]),
		.plane3_c (pl[10]),
		.plane3_d (pl[11]),
		.empty    (empty),
		.pop      (pop),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.singular (singular),
		.overflow (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// 3x3 determinant of rows (r0, r1, r2), exact
	function automatic wide_t det3(input wide_t m [9]);
		return m[0] * (m[4] * m[8] - m[5] * m[7])
			- m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
	endfunction

	// (num << FB) / den truncated toward zero, saturated to PT_W bits
	function automatic logic signed [PT_W-1:0] fix_quot(input wide_t num, input wide_t den,
			inout logic ovf);
		wide_t q;
		q = (num <<< FB) / den;   // SV signed division truncates toward zero
		if (q > wide_t'(32'sh7FFFFFFF)) begin
			ovf = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (q < -wide_t'(64'sh80000000)) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return q[PT_W-1:0];
	endfunction

	function automatic point_t solve_planes(input coef_t c [12]);
		wide_t m [9];
		wide_t nd [3];
		wide_t dm;
		point_t p;
		logic ovf;
		ovf = 1'b0;
		for (int r = 0; r < 3; r++) begin
			m[3*r]   = wide_t'(c[4*r]);
			m[3*r+1] = wide_t'(c[4*r+1]);
			m[3*r+2] = wide_t'(c[4*r+2]);
			nd[r]    = -wide_t'(c[4*r+3]);
		end
		dm = det3(m);
		p.sing = (dm == 0);
		p.x = '0;
		p.y = '0;
		p.z = '0;
		if (!p.sing) begin
			for (int k = 0; k < 3; k++) begin
				wide_t mk [9];
				mk = m;
				for (int r = 0; r < 3; r++) mk[3*r+k] = nd[r];
				case (k)
					0: p.x = fix_quot(det3(mk), dm, ovf);
					1: p.y = fix_quot(det3(mk), dm, ovf);
					default: p.z = fix_quot(det3(mk), dm, ovf);
				endcase
			end
		end
		p.ovf = ovf;
		return p;
	endfunction

	// one transfer into the block; predicted point queued at the accepting edge
	// push stays high after a transfer so items can follow back to back
	task automatic send_planes(input coef_t c [12]);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		for (int i = 0; i < 12; i++) pl[i] <= c[i];
		@(posedge clk);
		while (full) @(posedge clk);
		expected_points.push_back(solve_planes(c));
		n_sent++;
	endtask

	function automatic coef_t rand_coef(input int mode);
		case (mode)
			0: return coef_t'($urandom);
			1: return coef_t'($signed($urandom_range(0, 20)) - 10) <<< FB;
			2: return coef_t'($signed($urandom_range(0, 65535)) - 32768);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'sh80000000;
					1: return 32'sh7FFFFFFF;
					2: return 32'sh0;
					default: return -32'sh1;
				endcase
			end
		endcase
	endfunction

	// result side: random pop bursts, compare in order
	always @(posedge clk) begin
		point_t e;
		if (arst_n && pop && !empty) begin
			if (expected_points.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_points.pop_front();
				n_checked++;
				if (point_x !== e.x) begin
					$error("point_x exp %0d got %0d", e.x, point_x); errors++;
				end
				if (point_y !== e.y) begin
					$error("point_y exp %0d got %0d", e.y, point_y); errors++;
				end
				if (point_z !== e.z) begin
					$error("point_z exp %0d got %0d", e.z, point_z); errors++;
				end
				if (singular !== e.sing) begin
					$error("singular exp %0b got %0b", e.sing, singular); errors++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow exp %0b got %0b", e.ovf, overflow); errors++;
				end
				if (e.sing) n_singular++;
				if (e.ovf) n_overflow++;
			end
		end
	end

	// pop driver: stalls in bursts, or holds off entirely on request
	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_pop) begin
				pop <= 1'b0;
				@(posedge clk);
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 12);
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic test_directed();
		coef_t c [12];
		// identity planes: x=1, y=-2, z=3
		c = '{32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000, 0, 32'sh20000,
			0, 0, 32'sh10000, -32'sh30000};
		send_planes(c);
		// all zero: singular
		c = '{default: 0};
		send_planes(c);
		// two parallel planes: singular with nonzero d
		c = '{32'sh10000, 32'sh10000, 0, 5, 32'sh20000, 32'sh20000, 0, 7,
			0, 0, 32'sh10000, 1};
		send_planes(c);
		// tiny diagonal, big d: positive and negative saturation
		c = '{1, 0, 0, 32'sh80000000, 0, 1, 0, 32'sh7FFFFFFF, 0, 0, 1, 32'sh80000000};
		send_planes(c);
		// most negative coefficients everywhere on a diagonal
		c = '{32'sh80000000, 0, 0, 32'sh80000000, 0, 32'sh80000000, 0, 32'sh7FFFFFFF,
			0, 0, 32'sh80000000, 0};
		send_planes(c);
		// all maxima / all minima (singular)
		c = '{default: 32'sh7FFFFFFF};
		send_planes(c);
		c = '{default: 32'sh80000000};
		send_planes(c);
		// results near the saturation bounds: x negative, y and z positive
		c = '{32'sh10000, 0, 0, 32'sh7FFF0000, 0, -32'sh10000, 0, 32'sh7FFF0000,
			0, 0, 32'sh10000, -32'sh7FFF0000};
		send_planes(c);
		// fractional truncation toward zero
		c = '{32'sh30000, 0, 0, 32'sh10000, 0, 32'sh30000, 0, -32'sh10000,
			0, 0, -32'sh70000, 32'sh20001};
		send_planes(c);
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 12; i++) c[i] = rand_coef(3);
			send_planes(c);
		end
	endtask

	task automatic test_random(input int count);
		coef_t c [12];
		int mode;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 12; i++) c[i] = rand_coef(mode);
			// sometimes force a singular system by copying a row
			if ($urandom_range(0, 9) == 0)
				for (int i = 0; i < 3; i++) c[4 + i] = c[i];
			send_planes(c);
		end
	endtask

	// receiver stops long enough for the block to fill and raise full
	task automatic test_backpressure();
		coef_t c [12];
		int held;
		hold_pop = 1'b1;
		held = 0;
		fork
			begin
				while (held < 300) begin
					@(posedge clk);
					held++;
				end
				hold_pop = 1'b0;
			end
			begin
				while (held < 280) begin
					for (int i = 0; i < 12; i++) c[i] = rand_coef(1);
					send_planes(c);
				end
			end
		join
		hold_pop = 1'b0;
	endtask

	initial begin
		int waited;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_singular = 0;
		n_overflow = 0;
		idle_enable = 1'b1;
		hold_pop = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		for (int i = 0; i < 12; i++) pl[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(300);
		test_backpressure();
		test_random(250);
		idle_enable = 1'b0;   // closing stretch runs at full rate
		test_random(120);
		push <= 1'b0;

		waited = 0;
		while (expected_points.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d plane triples, checked %0d points", n_sent, n_checked);
		$display("singular systems %0d, saturated points %0d", n_singular, n_overflow);
		if (errors == 0 && expected_points.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("status: fail");
		$finish;
	end

endmodule
